// ===== sv/drw_pkg.sv =====
// ----------------------------------------------------------------------------
// drw_pkg: shared types and constants for the delta regression window unit
// Field widths, item and register codes, controller state and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package drw_pkg;

    // default parameter values
    localparam int HALF_WINDOW_DEF  = 2;
    localparam int MAX_FEATURES_DEF = 32;
    localparam int DATA_WIDTH_DEF   = 32;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 5;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int CPB_W      = 6;
    localparam int BC_W       = 3;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRAP_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFS_PER_BLOCK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT     = 2'd2;

    // register reset values
    localparam logic [CPB_W-1:0] CPB_RESET = 6'd13;
    localparam logic [BC_W-1:0]  BC_RESET  = 3'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PREV_RD,
        ST_PREV_CAP,
        ST_WRITE,
        ST_RD,
        ST_USE,
        ST_DIV,
        ST_EMIT,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic take_item;
        logic restart;
        logic prev_rd;
        logic prev_cap;
        logic wr_step;
        logic rd_issue;
        logic use_step;
        logic acc_step;
        logic div_start;
        logic out_trap;
        logic out_delta;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic fill_zero;
        logic fill_ge_w;
        logic flush_full;
        logic idx_ok;
        logic wr_done;
        logic trap_mode;
        logic trap_ok;
        logic has_delta;
        logic pos_last;
        logic out_free;
        logic div_done;
    } dp_status_t;

endpackage

// ===== sv/drw_ram.sv =====
// ----------------------------------------------------------------------------
// drw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module drw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/drw_div.sv =====
// ----------------------------------------------------------------------------
// drw_div: signed divide by a constant, truncating toward zero
// Long division of the magnitude in base 256, one digit per cycle; each
// quotient digit comes from a small reciprocal multiplication.
// ----------------------------------------------------------------------------
module drw_div #(
    parameter int ACC_W = 39,
    parameter int DEN   = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    output logic                    done,
    output logic signed [ACC_W-1:0] quo
);

    localparam int DIG_W = 8;
    localparam int NDIG  = (ACC_W + DIG_W - 1) / DIG_W;
    localparam int MAG_W = NDIG * DIG_W;
    localparam int REM_W = $clog2(DEN);
    localparam int X_W   = REM_W + DIG_W;
    localparam int SHIFT = X_W + REM_W;
    localparam int RCP_W = X_W + 1;
    localparam int PRD_W = X_W + RCP_W;
    localparam int CNT_W = $clog2(NDIG + 1);
    // ceil(2^SHIFT / DEN): exact quotient for any partial value below 2^X_W
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'(1) << SHIFT) + 64'(DEN - 1)) / 64'(DEN));
    localparam logic [X_W-1:0] DEN_X = X_W'(DEN);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] num_abs;
    logic [X_W-1:0]   part;
    logic [PRD_W-1:0] prd;
    logic [DIG_W-1:0] q_dig;
    logic [X_W-1:0]   back;
    logic [ACC_W-1:0] q_mag;

    // one base-256 digit: remainder joined with the next dividend digit
    assign num_abs = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign part    = {rem_reg, mag_reg[MAG_W-1 -: DIG_W]};
    assign prd     = PRD_W'(part) * PRD_W'(RECIP);
    assign q_dig   = DIG_W'(prd >> SHIFT);
    assign back    = X_W'(q_dig) * DEN_X;
    assign q_mag   = mag_reg[ACC_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            neg_next  = num[ACC_W-1];
            mag_next  = MAG_W'(num_abs);
            rem_next  = '0;
            cnt_next  = CNT_W'(NDIG);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[MAG_W-DIG_W-1:0], q_dig};
            rem_next = REM_W'(part - back);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_mag) : $signed(q_mag);

endmodule

// ===== sv/drw_datapath.sv =====
// ----------------------------------------------------------------------------
// drw_datapath: window store, counters, accumulator and result register
// Carries out the controller's commands one step per cycle.
// ----------------------------------------------------------------------------
module drw_datapath
    import drw_pkg::*;
#(
    parameter int HALF_WINDOW  = HALF_WINDOW_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [KIND_W-1:0]            kind,
    input  logic [IDX_W-1:0]             coef_index,
    input  logic signed [DATA_WIDTH-1:0] coef_value,
    input  logic                         frame_last,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [IDX_W-1:0]             out_index,
    output logic signed [DATA_WIDTH-1:0] center_value,
    output logic signed [DATA_WIDTH-1:0] delta_value,
    output logic                         has_delta,
    output logic [POS_W-1:0]             window_pos,
    output logic                         run_last,
    output logic                         frame_end
);

    localparam int DWLEN  = 2 * HALF_WINDOW + 1;
    localparam int DEPTH  = DWLEN * MAX_FEATURES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(DWLEN);
    localparam int CNT_W  = $clog2(HALF_WINDOW + 1);
    localparam int REP_W  = $clog2(HALF_WINDOW + 2);
    localparam int ACC_W  = DATA_WIDTH + 7;
    localparam int PROD_W = DATA_WIDTH + POS_W + 1;
    localparam int DEN    = HALF_WINDOW * (HALF_WINDOW + 1) * (2 * HALF_WINDOW + 1) / 3;
    localparam int RNG_W  = CPB_W + BC_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DWLEN - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    // configuration
    logic             trap_mode_reg;
    logic [CPB_W-1:0] cpb_reg;
    logic [BC_W-1:0]  bc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trap_mode_reg <= 1'b0;
            cpb_reg       <= CPB_RESET;
            bc_reg        <= BC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRAP_MODE:       trap_mode_reg <= cfg_data[0];
                CFG_COEFS_PER_BLOCK: cpb_reg       <= cfg_data[CPB_W-1:0];
                CFG_BLOCK_COUNT:     bc_reg        <= cfg_data[BC_W-1:0];
                default:             ;
            endcase
        end
    end

    // item registers
    logic [KIND_W-1:0]            kind_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic                         last_reg;
    logic signed [DATA_WIDTH-1:0] rd_data;

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            kind_reg  <= kind;
            idx_reg   <= coef_index;
            value_reg <= coef_value;
            last_reg  <= frame_last;
        end
        else if (cmd.prev_cap)
        begin
            value_reg <= rd_data;
        end
    end

    // window counters
    logic [SLOT_W-1:0] ws_reg, ws_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  flush_reg, flush_next;
    logic [SLOT_W:0]   ws_skip;
    logic              first;

    assign first   = (kind_reg == KIND_DATA) && (fill_reg == '0);
    assign ws_skip = {1'b0, ws_reg} + (SLOT_W + 1)'(HALF_WINDOW + 1);

    always_comb
    begin
        ws_next    = ws_reg;
        fill_next  = fill_reg;
        flush_next = flush_reg;
        if (cmd.restart)
        begin
            ws_next    = '0;
            fill_next  = '0;
            flush_next = '0;
        end
        else if (cmd.commit && last_reg)
        begin
            if (first)
            begin
                ws_next   = (ws_skip >= (SLOT_W + 1)'(DWLEN))
                          ? SLOT_W'(ws_skip - (SLOT_W + 1)'(DWLEN))
                          : SLOT_W'(ws_skip);
                fill_next = CNT_W'(1);
            end
            else
            begin
                ws_next = slot_inc(ws_reg);
                if (fill_reg < CNT_W'(HALF_WINDOW))
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            if (kind_reg == KIND_FLUSH)
            begin
                flush_next = flush_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg    <= '0;
            fill_reg  <= '0;
            flush_reg <= '0;
        end
        else
        begin
            ws_reg    <= ws_next;
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
        end
    end

    // slot walker, write count and window position
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [REP_W-1:0]  wr_cnt_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [REP_W-1:0]  reps_m1;
    logic              wr_done;

    assign reps_m1 = first ? REP_W'(HALF_WINDOW) : '0;
    assign wr_done = (wr_cnt_reg == reps_m1);

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            cur_slot_reg <= ws_reg;
            wr_cnt_reg   <= '0;
        end
        else if (cmd.wr_step)
        begin
            if (wr_done)
            begin
                cur_slot_reg <= slot_inc(ws_reg);
                pos_reg      <= '0;
            end
            else
            begin
                cur_slot_reg <= slot_inc(cur_slot_reg);
                wr_cnt_reg   <= wr_cnt_reg + 1'b1;
            end
        end
        else if (cmd.use_step)
        begin
            cur_slot_reg <= slot_inc(cur_slot_reg);
            pos_reg      <= pos_reg + 1'b1;
        end
    end

    // window store
    logic [SLOT_W-1:0] prev_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign prev_slot = (ws_reg == '0) ? SLOT_LAST : ws_reg - 1'b1;
    assign rd_slot   = cmd.prev_rd ? prev_slot : cur_slot_reg;
    assign rd_addr   = ADDR_W'(32'(rd_slot) * MAX_FEATURES + 32'(idx_reg));
    assign wr_addr   = ADDR_W'(32'(cur_slot_reg) * MAX_FEATURES + 32'(idx_reg));

    drw_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_step),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (cmd.prev_rd || cmd.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // weighted sum: weight is the window position less the half width
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [DATA_WIDTH-1:0] centre_reg;
    logic signed [POS_W:0]    wgt;
    logic signed [PROD_W-1:0] prod;

    assign wgt      = $signed({1'b0, pos_reg}) - $signed((POS_W + 1)'(HALF_WINDOW));
    assign prod     = wgt * rd_data;
    assign acc_next = acc_reg + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_step && wr_done)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_step)
        begin
            acc_reg <= acc_next;
            if (pos_reg == POS_W'(HALF_WINDOW))
            begin
                centre_reg <= rd_data;
            end
        end
    end

    // divide and saturate; the divider takes the sum with the last term in
    logic                    div_done;
    logic signed [ACC_W-1:0] quo;
    logic signed [ACC_W-1:0] quo_sat;

    drw_div #(
        .ACC_W (ACC_W),
        .DEN   (DEN)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_next),
        .done  (div_done),
        .quo   (quo)
    );

    assign quo_sat = (quo > SAT_HI) ? SAT_HI : ((quo < SAT_LO) ? SAT_LO : quo);

    // delta range of the last block
    logic [RNG_W-1:0] blk_lo;
    logic [RNG_W-1:0] blk_hi;
    logic             hd;

    assign blk_lo = RNG_W'(cpb_reg * (bc_reg - 1'b1));
    assign blk_hi = RNG_W'(cpb_reg * bc_reg);
    assign hd     = (bc_reg != '0) && (cpb_reg != '0)
                 && (RNG_W'(idx_reg) >= blk_lo) && (RNG_W'(idx_reg) < blk_hi);

    // result register
    logic out_valid_reg;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_trap || cmd.out_delta)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_trap)
        begin
            out_index    <= idx_reg;
            center_value <= rd_data;
            delta_value  <= '0;
            has_delta    <= 1'b0;
            window_pos   <= pos_reg;
            run_last     <= (pos_reg == POS_W'(DWLEN - 1));
            frame_end    <= last_reg;
        end
        else if (cmd.out_delta)
        begin
            out_index    <= idx_reg;
            center_value <= centre_reg;
            delta_value  <= hd ? DATA_WIDTH'(quo_sat) : '0;
            has_delta    <= hd;
            window_pos   <= '0;
            run_last     <= 1'b1;
            frame_end    <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // status to the controller
    always_comb
    begin
        status.kind       = kind_reg;
        status.fill_zero  = (fill_reg == '0);
        status.fill_ge_w  = (fill_reg >= CNT_W'(HALF_WINDOW));
        status.flush_full = (flush_reg >= CNT_W'(HALF_WINDOW));
        status.idx_ok     = (32'(idx_reg) < MAX_FEATURES);
        status.wr_done    = wr_done;
        status.trap_mode  = trap_mode_reg;
        status.trap_ok    = (CPB_W'(idx_reg) < cpb_reg);
        status.has_delta  = hd;
        status.pos_last   = (pos_reg == POS_W'(DWLEN - 1));
        status.out_free   = out_free;
        status.div_done   = div_done;
    end

endmodule

// ===== sv/drw_ctrl.sv =====
// ----------------------------------------------------------------------------
// drw_ctrl: sequencer for the delta regression window unit
// Steps one word through prefetch, window writes, window reads and output.
// ----------------------------------------------------------------------------
module drw_ctrl
    import drw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                case (status.kind)
                    KIND_RESTART:
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    KIND_FLUSH:
                    begin
                        if (status.fill_zero || status.flush_full)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (status.idx_ok)
                        begin
                            state_next = ST_PREV_RD;
                        end
                        else
                        begin
                            state_next = ST_COMMIT;
                        end
                    end
                    KIND_DATA:
                    begin
                        state_next = status.idx_ok ? ST_WRITE : ST_COMMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            // flush repeats the previous frame's entry
            ST_PREV_RD:
            begin
                cmd.prev_rd = 1'b1;
                state_next  = ST_PREV_CAP;
            end
            ST_PREV_CAP:
            begin
                cmd.prev_cap = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr_step = 1'b1;
                if (status.wr_done)
                begin
                    if (status.fill_ge_w && (!status.trap_mode || status.trap_ok))
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_USE;
            end
            ST_USE:
            begin
                if (status.trap_mode)
                begin
                    if (status.out_free)
                    begin
                        cmd.out_trap = 1'b1;
                        if (status.pos_last)
                        begin
                            state_next = ST_COMMIT;
                        end
                        else
                        begin
                            cmd.use_step = 1'b1;
                            state_next   = ST_RD;
                        end
                    end
                end
                else
                begin
                    cmd.acc_step = 1'b1;
                    if (status.pos_last)
                    begin
                        if (status.has_delta)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        cmd.use_step = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_delta = 1'b1;
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/delta_regression_window_unit.sv =====
// ----------------------------------------------------------------------------
// delta_regression_window_unit: streaming delta coefficient unit
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | in_valid/in_stall   | kind, coef_index, coef_value, frame_last
//   output  | out_valid/out_stall | out_index, center_value, delta_value,
//           |                     | has_delta, window_pos, run_last, frame_end
//   config  | cfg_we              | cfg_index, cfg_data
//
// One word at a time. A data word passes decide, R window writes (R = W+1 on
// the first frame, else 1) and commit; when it reads the window, L = 2W+1
// reads come between, each a read then a use. Outside trap mode an emit step
// follows the reads, preceded in the last block by the divider. A flush word
// first fetches the previous entry with a previous read and a capture.
// Output stalls hold the sequencer only when the result register is full.
// Reset clears state, window counters, configuration and out_valid; not the store.
// ----------------------------------------------------------------------------
module delta_regression_window_unit
    import drw_pkg::*;
#(
    parameter int HALF_WINDOW  = HALF_WINDOW_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [KIND_W-1:0]            kind,
    input  logic [IDX_W-1:0]             coef_index,
    input  logic signed [DATA_WIDTH-1:0] coef_value,
    input  logic                         frame_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [IDX_W-1:0]             out_index,
    output logic signed [DATA_WIDTH-1:0] center_value,
    output logic signed [DATA_WIDTH-1:0] delta_value,
    output logic                         has_delta,
    output logic [POS_W-1:0]             window_pos,
    output logic                         run_last,
    output logic                         frame_end
);

    dp_cmd_t    cmd;
    dp_status_t status;

    drw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    drw_datapath #(
        .HALF_WINDOW  (HALF_WINDOW),
        .MAX_FEATURES (MAX_FEATURES),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .frame_last   (frame_last),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_index    (out_index),
        .center_value (center_value),
        .delta_value  (delta_value),
        .has_delta    (has_delta),
        .window_pos   (window_pos),
        .run_last     (run_last),
        .frame_end    (frame_end)
    );

endmodule

// ===== sv/drw_checker.sv =====
// ----------------------------------------------------------------------------
// drw_checker: port-level checks for the delta regression window unit
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module drw_checker
    import drw_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [IDX_W-1:0]             out_index,
    input logic signed [DATA_WIDTH-1:0] center_value,
    input logic signed [DATA_WIDTH-1:0] delta_value,
    input logic                         has_delta,
    input logic [POS_W-1:0]             window_pos,
    input logic                         run_last
);

    // a word just taken keeps the unit busy for the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a word");

    // a delta result is a single result at window position zero
    a_delta_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_delta |-> window_pos == '0 && run_last)
        else $error("delta result not a single centre word");

    // window words carry no delta
    a_window_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_pos != '0 |-> !has_delta && delta_value == '0)
        else $error("window word carries a delta");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_index)
            && $stable(center_value) && $stable(delta_value)
            && $stable(window_pos) && $stable(run_last))
        else $error("stalled result changed");

endmodule

bind delta_regression_window_unit drw_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_drw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_index    (out_index),
    .center_value (center_value),
    .delta_value  (delta_value),
    .has_delta    (has_delta),
    .window_pos   (window_pos),
    .run_last     (run_last)
);
